// ===== sv/ucvc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the UTF-8 config value checker.
// No dependencies; every other file in this block imports this package.
package ucvc_pkg;

    // Width of the saturating byte counter of one value.
    localparam int COUNT_BITS = 17;
    localparam int MAX_LEN_BITS = 16;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic [MAX_LEN_BITS-1:0] MAX_LENGTH_RESET = 16'd4096;
    // Word index of the max_length register on the configuration port.
    localparam logic REG_MAX_LENGTH = 1'b0;

    // Lead and continuation byte bounds of strict UTF-8.
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;
    localparam logic [7:0] CONT_LO = 8'h80;
    localparam logic [7:0] CONT_HI = 8'hBF;
    localparam logic [7:0] CONT_A0 = 8'hA0;
    localparam logic [7:0] CONT_9F = 8'h9F;
    localparam logic [7:0] CONT_90 = 8'h90;
    localparam logic [7:0] CONT_8F = 8'h8F;
    localparam logic [7:0] ASCII_HI = 8'h7F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_DEL = 8'h7F;

    typedef enum logic [2:0] {
        RULE_ANY    = 3'd0,
        RULE_A0_BF  = 3'd1,
        RULE_80_9F  = 3'd2,
        RULE_90_BF  = 3'd3,
        RULE_80_8F  = 3'd4
    } cont_rule_t;

    typedef enum logic [2:0] {
        REASON_OK         = 3'd0,
        REASON_EMPTY      = 3'd1,
        REASON_TOO_LONG   = 3'd2,
        REASON_LEAD_BLANK = 3'd3,
        REASON_TRAIL_BLANK = 3'd4,
        REASON_CONTROL    = 3'd5,
        REASON_BAD_UTF8   = 3'd6
    } reason_t;

    typedef struct packed {
        logic [1:0] pending;
        cont_rule_t rule;
        logic       error;
    } utf8_state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_value;
    } in_item_t;

    typedef struct packed {
        logic    value_ok;
        reason_t reason;
    } out_item_t;

endpackage

// ===== sv/ucvc_utf8_step.sv =====
`timescale 1ns / 1ps
// Strict UTF-8 sequence tracker: next decoder state from the current state and one byte.
// Depends on ucvc_pkg.
module ucvc_utf8_step (
    input  ucvc_pkg::utf8_state_t cur_state,
    input  logic [7:0]            data_byte,
    output ucvc_pkg::utf8_state_t nxt_state
);
    import ucvc_pkg::*;

    logic cont_ok;

    always_comb begin
        case (cur_state.rule)
            RULE_A0_BF: cont_ok = data_byte inside {[CONT_A0:CONT_HI]};
            RULE_80_9F: cont_ok = data_byte inside {[CONT_LO:CONT_9F]};
            RULE_90_BF: cont_ok = data_byte inside {[CONT_90:CONT_HI]};
            RULE_80_8F: cont_ok = data_byte inside {[CONT_LO:CONT_8F]};
            default:    cont_ok = data_byte inside {[CONT_LO:CONT_HI]};
        endcase
    end

    always_comb begin
        nxt_state = cur_state;
        if (cur_state.pending != 2'd0) begin
            // A bad continuation drops the sequence; the next byte starts fresh.
            nxt_state.rule = RULE_ANY;
            if (cont_ok) begin
                nxt_state.pending = cur_state.pending - 2'd1;
            end else begin
                nxt_state.pending = 2'd0;
                nxt_state.error   = 1'b1;
            end
        end else if (data_byte <= ASCII_HI) begin
            nxt_state = cur_state;
        end else if (data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
            nxt_state.pending = 2'd1;
            nxt_state.rule    = RULE_ANY;
        end else if (data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
            nxt_state.pending = 2'd2;
            if (data_byte == LEAD3_LO) begin
                nxt_state.rule = RULE_A0_BF;
            end else if (data_byte == LEAD3_SURR) begin
                nxt_state.rule = RULE_80_9F;
            end else begin
                nxt_state.rule = RULE_ANY;
            end
        end else if (data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
            nxt_state.pending = 2'd3;
            if (data_byte == LEAD4_LO) begin
                nxt_state.rule = RULE_90_BF;
            end else if (data_byte == LEAD4_HI) begin
                nxt_state.rule = RULE_80_8F;
            end else begin
                nxt_state.rule = RULE_ANY;
            end
        end else begin
            nxt_state.error = 1'b1;
        end
    end

endmodule

// ===== sv/ucvc_value_state.sv =====
`timescale 1ns / 1ps
// Running per-value state (count, blank and control flags, UTF-8 tracker) and the verdict.
// Depends on ucvc_pkg and ucvc_utf8_step.
module ucvc_value_state (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  item_fire,
    input  ucvc_pkg::in_item_t                    item,
    input  logic [ucvc_pkg::MAX_LEN_BITS-1:0]     max_length,
    output ucvc_pkg::out_item_t                   verdict
);
    import ucvc_pkg::*;

    logic [COUNT_BITS-1:0] count_reg, count_next, count_upd;
    logic                  lead_reg, lead_next, lead_upd;
    logic                  ctrl_reg, ctrl_next, ctrl_upd;
    utf8_state_t           utf8_reg, utf8_next, utf8_upd;
    logic                  blank;
    logic                  too_long;
    reason_t               reason;

    ucvc_utf8_step u_utf8_step (
        .cur_state (utf8_reg),
        .data_byte (item.data_byte),
        .nxt_state (utf8_upd)
    );

    // The trailing-blank test only ever needs the byte that closes the value,
    // so the current byte stands in for the previous-byte flag.
    always_comb begin
        blank     = (item.data_byte == CHAR_SPACE) || (item.data_byte == CHAR_TAB);
        lead_upd  = lead_reg || ((count_reg == '0) && blank);
        ctrl_upd  = ctrl_reg || (item.data_byte < CHAR_SPACE) || (item.data_byte == CHAR_DEL);
        count_upd = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        too_long  = 33'(count_upd) > 33'(max_length);

        if (too_long) begin
            reason = REASON_TOO_LONG;
        end else if (lead_upd) begin
            reason = REASON_LEAD_BLANK;
        end else if (blank) begin
            reason = REASON_TRAIL_BLANK;
        end else if (ctrl_upd) begin
            reason = REASON_CONTROL;
        end else if (utf8_upd.error || (utf8_upd.pending != 2'd0)) begin
            reason = REASON_BAD_UTF8;
        end else begin
            reason = REASON_OK;
        end
        if (item.empty_value) begin
            reason = REASON_EMPTY;
        end
        verdict.reason   = reason;
        verdict.value_ok = (reason == REASON_OK);
    end

    always_comb begin
        count_next      = count_reg;
        lead_next       = lead_reg;
        ctrl_next       = ctrl_reg;
        utf8_next       = utf8_reg;
        if (item_fire) begin
            // A final byte or an empty marker closes the value.
            if (item.empty_value || item.last_byte) begin
                count_next      = '0;
                lead_next       = 1'b0;
                ctrl_next       = 1'b0;
                utf8_next       = '{pending: 2'd0, rule: RULE_ANY, error: 1'b0};
            end else begin
                count_next      = count_upd;
                lead_next       = lead_upd;
                ctrl_next       = ctrl_upd;
                utf8_next       = utf8_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            lead_reg       <= 1'b0;
            ctrl_reg       <= 1'b0;
            utf8_reg       <= '{pending: 2'd0, rule: RULE_ANY, error: 1'b0};
        end else begin
            count_reg      <= count_next;
            lead_reg       <= lead_next;
            ctrl_reg       <= ctrl_next;
            utf8_reg       <= utf8_next;
        end
    end

endmodule

// ===== sv/utf8_config_value_checker.sv =====
`timescale 1ns / 1ps
// Top level of the UTF-8 config value checker: input register, value state, result register,
// APB register. Depends on ucvc_pkg, ucvc_value_state and ucvc_utf8_step.
//
//  Channel   Ports                            Moves
//  input     s_valid s_ready s_item           one byte of a value, or an empty marker
//  result    m_valid m_ready m_result         one verdict per final byte or empty marker
//  config    psel penable pwrite paddr ...    max_length at byte address 0
//
// A request is registered in the input register on acceptance and its verdict in the result
// register, which drives m_valid; one request per cycle is sustained while no verdict waits
// on a stalled result. The rate is set by the state update between the two registers.
// Reset is synchronous on aresetn and sets max_length to 4096 and clears all value state.
// A final byte or empty marker waits in the input register while a verdict is stalled, and
// that stalls the input; plain bytes keep flowing while no such request waits.
module utf8_config_value_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  ucvc_pkg::in_item_t                     s_item,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output ucvc_pkg::out_item_t                    m_result,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ucvc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [ucvc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [ucvc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                   pready
);
    import ucvc_pkg::*;

    logic                    in_vld_reg, in_vld_next;
    in_item_t                in_item_reg, in_item_next;
    logic                    out_vld_reg, out_vld_next;
    out_item_t               out_item_reg, out_item_next;
    logic [MAX_LEN_BITS-1:0] max_len_reg, max_len_next;
    logic                    gives_result;
    logic                    out_free;
    logic                    item_fire;
    out_item_t               verdict;
    logic                    reg_sel;

    assign reg_sel      = (paddr[APB_ADDR_BITS-1] == REG_MAX_LENGTH);
    assign pready       = 1'b1;
    assign prdata       = reg_sel ? APB_DATA_BITS'(max_len_reg) : '0;

    assign gives_result = in_item_reg.last_byte || in_item_reg.empty_value;
    assign out_free     = !out_vld_reg || m_ready;
    assign item_fire    = in_vld_reg && (!gives_result || out_free);
    assign s_ready      = !in_vld_reg || item_fire;
    assign m_valid      = out_vld_reg;
    assign m_result     = out_item_reg;

    ucvc_value_state u_value_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_fire  (item_fire),
        .item       (in_item_reg),
        .max_length (max_len_reg),
        .verdict    (verdict)
    );

    always_comb begin
        in_vld_next   = in_vld_reg;
        in_item_next  = in_item_reg;
        out_vld_next  = out_vld_reg;
        out_item_next = out_item_reg;
        max_len_next  = max_len_reg;

        if (s_valid && s_ready) begin
            in_vld_next  = 1'b1;
            in_item_next = s_item;
        end else if (item_fire) begin
            in_vld_next = 1'b0;
        end

        if (item_fire && gives_result) begin
            out_vld_next  = 1'b1;
            out_item_next = verdict;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end

        if (psel && penable && pwrite && pready && reg_sel) begin
            max_len_next = pwdata[MAX_LEN_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            max_len_reg <= MAX_LENGTH_RESET;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            max_len_reg <= max_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    // An empty marker always yields the empty verdict in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && in_item_reg.empty_value |=>
            m_valid && (m_result.reason == REASON_EMPTY) && !m_result.value_ok)
        else $error("empty marker did not give the empty verdict");

    // value_ok and the reason code must agree on every shown verdict.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.value_ok == (m_result.reason == REASON_OK)))
        else $error("value_ok disagrees with reason");

    // A plain byte never creates a verdict.
    assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && !gives_result && !m_valid |=> !m_valid)
        else $error("verdict produced without a final byte");

    // The input register is only blocked while a verdict waits on a stalled result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_vld_reg && gives_result && m_valid && !m_ready)
        else $error("input stalled without a waiting verdict");

endmodule

// ===== sim/utf8_config_value_checker_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_config_value_checker: queued requests, a predictor,
// a verdict checker, APB accesses to max_length. Depends on ucvc_pkg and the block's RTL.
module utf8_config_value_checker_tb;
    import ucvc_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] FILL_CHAR = 8'h61;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    in_item_t                 s_item = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    out_item_t                m_result;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    in_item_t  byte_requests[$];
    out_item_t expected_verdicts[$];
    out_item_t predicted;
    int        items_queued = 0;
    int        errors = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        holds_requested = 0;
    int        holds_granted = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    // Predictor copy of the per-value state and of the length register.
    logic [1:0]            cont_owed = '0;
    cont_rule_t            next_cont_rule = RULE_ANY;
    logic [COUNT_BITS-1:0] value_len = '0;
    logic                  lead_blank = 1'b0;
    logic                  last_was_blank = 1'b0;
    logic                  has_control = 1'b0;
    logic                  utf8_bad = 1'b0;
    logic [MAX_LEN_BITS-1:0] length_limit = MAX_LENGTH_RESET;

    utf8_config_value_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic void clear_value_state();
        cont_owed = '0;
        next_cont_rule = RULE_ANY;
        value_len = '0;
        lead_blank = 1'b0;
        last_was_blank = 1'b0;
        has_control = 1'b0;
        utf8_bad = 1'b0;
    endfunction

    function automatic logic cont_fits(input logic [7:0] b, input cont_rule_t rule);
        case (rule)
            RULE_A0_BF: return b >= CONT_A0 && b <= CONT_HI;
            RULE_80_9F: return b >= CONT_LO && b <= CONT_9F;
            RULE_90_BF: return b >= CONT_90 && b <= CONT_HI;
            RULE_80_8F: return b >= CONT_LO && b <= CONT_8F;
            default:    return b >= CONT_LO && b <= CONT_HI;
        endcase
    endfunction

    // Updates the running state with one request; returns 1 when it ends a value.
    function automatic bit predict_verdict(input in_item_t req, output out_item_t verdict);
        logic [7:0] b;
        logic       blank;
        reason_t    why;
        b = req.data_byte;
        verdict = '0;
        if (req.empty_value) begin
            clear_value_state();
            verdict.value_ok = 1'b0;
            verdict.reason = REASON_EMPTY;
            return 1'b1;
        end
        blank = (b == CHAR_SPACE) || (b == CHAR_TAB);
        if (value_len == '0 && blank) lead_blank = 1'b1;
        last_was_blank = blank;
        if (b < CHAR_SPACE || b == CHAR_DEL) has_control = 1'b1;
        if (cont_owed != 2'd0) begin
            if (cont_fits(b, next_cont_rule)) begin
                cont_owed = cont_owed - 2'd1;
            end else begin
                utf8_bad = 1'b1;
                cont_owed = 2'd0;
            end
            next_cont_rule = RULE_ANY;
        end else if (b <= ASCII_HI) begin
            // Plain ASCII needs no tracking.
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            cont_owed = 2'd1;
            next_cont_rule = RULE_ANY;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            cont_owed = 2'd2;
            next_cont_rule = (b == LEAD3_LO) ? RULE_A0_BF :
                             (b == LEAD3_SURR) ? RULE_80_9F : RULE_ANY;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            cont_owed = 2'd3;
            next_cont_rule = (b == LEAD4_LO) ? RULE_90_BF :
                             (b == LEAD4_HI) ? RULE_80_8F : RULE_ANY;
        end else begin
            utf8_bad = 1'b1;
        end
        if (value_len != {COUNT_BITS{1'b1}}) value_len = value_len + 1'b1;
        if (!req.last_byte) return 1'b0;
        if (value_len > length_limit) why = REASON_TOO_LONG;
        else if (lead_blank) why = REASON_LEAD_BLANK;
        else if (last_was_blank) why = REASON_TRAIL_BLANK;
        else if (has_control) why = REASON_CONTROL;
        else if (utf8_bad || cont_owed != 2'd0) why = REASON_BAD_UTF8;
        else why = REASON_OK;
        verdict.value_ok = (why == REASON_OK);
        verdict.reason = why;
        clear_value_state();
        return 1'b1;
    endfunction

    // Request driver: holds a request until it is taken, predicts on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (predict_verdict(s_item, predicted))
                    expected_verdicts = {expected_verdicts, predicted};
            end
            if (s_valid && !s_ready) begin
                // Keep offering the same request.
            end else if (byte_requests.size() != 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                s_item <= byte_requests.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Verdict monitor and receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: verdict expected none actual value_ok %0b reason %0d",
                             $time, m_result.value_ok, m_result.reason);
                    errors++;
                end else begin
                    predicted = expected_verdicts.pop_front();
                    if (m_result.value_ok !== predicted.value_ok) begin
                        $display("%0t: value_ok expected %0b actual %0b", $time,
                                 predicted.value_ok, m_result.value_ok);
                        errors++;
                    end
                    if (m_result.reason !== predicted.reason) begin
                        $display("%0t: reason expected %0d actual %0d", $time,
                                 predicted.reason, m_result.reason);
                        errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (holds_granted != holds_requested) begin
                m_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                holds_granted <= holds_granted + 1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_item_t make_request(input logic [7:0] b, input logic last,
                                              input logic empty);
        in_item_t req;
        req.data_byte = b;
        req.last_byte = last;
        req.empty_value = empty;
        return req;
    endfunction

    function automatic void add_request(input in_item_t req);
        byte_requests = {byte_requests, req};
    endfunction

    task automatic queue_value(input logic [7:0] value_bytes[$]);
        foreach (value_bytes[i])
            add_request(make_request(value_bytes[i], i == value_bytes.size() - 1, 1'b0));
        items_queued += value_bytes.size();
    endtask

    task automatic queue_empty_marker();
        add_request(make_request(8'($urandom), 1'($urandom), 1'b1));
        items_queued++;
    endtask

    function automatic logic [7:0] any_cont();
        if ($urandom_range(0, 99) < 5) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(CONT_LO, CONT_HI));
    endfunction

    // First continuation byte after a lead, mostly inside its legal range.
    function automatic logic [7:0] second_cont(input logic [7:0] lead);
        if ($urandom_range(0, 99) < 10) return 8'($urandom_range(0, 255));
        case (lead)
            LEAD3_LO:   return 8'($urandom_range(CONT_A0, CONT_HI));
            LEAD3_SURR: return 8'($urandom_range(CONT_LO, CONT_9F));
            LEAD4_LO:   return 8'($urandom_range(CONT_90, CONT_HI));
            LEAD4_HI:   return 8'($urandom_range(CONT_LO, CONT_8F));
            default:    return 8'($urandom_range(CONT_LO, CONT_HI));
        endcase
    endfunction

    task automatic queue_random_value(input int char_cap);
        logic [7:0] value_bytes[$];
        logic [7:0] lead;
        int roll;
        if ($urandom_range(0, 99) < 6) begin
            queue_empty_marker();
            return;
        end
        if ($urandom_range(0, 99) < 6)
            value_bytes = {value_bytes, ($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB)};
        repeat ($urandom_range(1, char_cap)) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                value_bytes = {value_bytes, 8'($urandom_range(CHAR_SPACE, CHAR_DEL - 1))};
            end else if (roll < 55) begin
                value_bytes = {value_bytes, 8'($urandom_range(LEAD2_LO, LEAD2_HI))};
                value_bytes = {value_bytes, any_cont()};
            end else if (roll < 75) begin
                case ($urandom_range(0, 2))
                    0: lead = LEAD3_LO;
                    1: lead = LEAD3_SURR;
                    default: lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
                endcase
                value_bytes = {value_bytes, lead};
                value_bytes = {value_bytes, second_cont(lead)};
                value_bytes = {value_bytes, any_cont()};
            end else if (roll < 88) begin
                case ($urandom_range(0, 2))
                    0: lead = LEAD4_LO;
                    1: lead = LEAD4_HI;
                    default: lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
                endcase
                value_bytes = {value_bytes, lead};
                value_bytes = {value_bytes, second_cont(lead)};
                value_bytes = {value_bytes, any_cont()};
                value_bytes = {value_bytes, any_cont()};
            end else if (roll < 94) begin
                value_bytes = {value_bytes, ($urandom_range(0, 1) ? CHAR_DEL :
                                             8'($urandom_range(0, CHAR_SPACE - 1)))};
            end else begin
                value_bytes = {value_bytes, 8'($urandom_range(0, 255))};
            end
        end
        if ($urandom_range(0, 99) < 6)
            value_bytes = {value_bytes, ($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB)};
        // Dropping the tail byte often leaves a multi-byte sequence cut short.
        if ($urandom_range(0, 99) < 6 && value_bytes.size() > 1) void'(value_bytes.pop_back());
        if ($urandom_range(0, 99) < 4) begin
            // The value is abandoned: an empty marker arrives before its final byte.
            foreach (value_bytes[i])
                add_request(make_request(value_bytes[i], 1'b0, 1'b0));
            items_queued += value_bytes.size();
            queue_empty_marker();
            return;
        end
        queue_value(value_bytes);
    endtask

    task automatic write_max_length(input logic [MAX_LEN_BITS-1:0] limit);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_MAX_LENGTH, 2'b00};
        pwdata <= {16'($urandom), limit};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        length_limit = limit;
    endtask

    task automatic check_max_length();
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {REG_MAX_LENGTH, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== APB_DATA_BITS'(length_limit)) begin
            $display("%0t: max_length read expected %0d actual %0d", $time,
                     length_limit, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Returns once every request is taken and every verdict is back, plus a short
    // settle so that trailing plain bytes have left the pipeline.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (byte_requests.size() != 0 || s_valid || expected_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [MAX_LEN_BITS-1:0] limit, input int idle_pct,
                             input int stall_pct, input int char_cap, input int item_goal);
        int goal_mark;
        wait_drained();
        write_max_length(limit);
        check_max_length();
        #1;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        goal_mark = items_queued + item_goal;
        while (items_queued < goal_mark) queue_random_value(char_cap);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        check_max_length();
        #1;

        queue_empty_marker();
        queue_value('{CHAR_DEL});
        queue_value('{CHAR_TAB, FILL_CHAR});
        queue_value('{FILL_CHAR, CHAR_SPACE});
        queue_value('{LEAD3_LO, CONT_9F, CONT_LO});
        queue_value('{LEAD3_SURR, CONT_A0});
        queue_value('{LEAD4_HI, CONT_90});
        queue_value('{LEAD4_LO, CONT_90, CONT_LO, CONT_LO});
        queue_value('{8'hE2, 8'h82});
        add_request(make_request(FILL_CHAR, 1'b0, 1'b0));
        queue_empty_marker();
        queue_value('{8'h62});
        queue_value('{8'hFF});

        run_phase(16'd1, 65, 0, 3, 100);
        run_phase(16'hFFFF, 0, 65, 8, 100);
        run_phase(16'd5, 8, 8, 6, 100);
        run_phase(16'd12, 0, 0, 6, 100);
        holds_requested++;
        run_phase(16'($urandom_range(2, 30)), 8, 8, 10, 100);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ucvc_pkg.sv
sv/ucvc_utf8_step.sv
sv/ucvc_value_state.sv
sv/utf8_config_value_checker.sv
sim/utf8_config_value_checker_tb.sv
